@@ hw/rtl/rcpfa_pkg.sv @@
// shared types, codes and width helpers of the page frame allocator
`timescale 1ns / 1ps
`default_nettype none

package rcpfa_pkg;

   // default build values
   localparam int DEFAULT_PAGE_COUNT  = 32768;
   localparam int DEFAULT_PAGE_SHIFT  = 12;
   localparam int DEFAULT_COUNT_WIDTH = 8;

   // configuration register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_END   = 1'b1;

   localparam logic [31:0] REGION_START_RESET = 32'h0000_0000;
   localparam logic [31:0] REGION_END_RESET   = 32'h0800_0000;

   // request kinds
   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_ADD     = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_OUT_OF_MEM  = 3'd1,
      STATUS_BAD_ADDRESS = 3'd2,
      STATUS_UNDERFLOW   = 3'd3,
      STATUS_OVERFLOW    = 3'd4
   } status_type;

   // outcome of the address and region check
   typedef struct packed {
      logic addr_ok;   // address names a managed page
      logic fresh_ok;  // an untouched page is still left
   } check_flags_type;

   // bits of a page index
   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // bits of a counter that can hold n itself
   function automatic int total_width(input int n);
      return $clog2(n + 1);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rcpfa_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rcpfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [rcpfa_pkg::idx_width(DEPTH)-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [rcpfa_pkg::idx_width(DEPTH)-1:0]     rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rcpfa_check.sv @@
// three stage address and region check: page base, page total, index range
`timescale 1ns / 1ps
`default_nettype none

module rcpfa_check #(
   parameter int PAGE_COUNT = rcpfa_pkg::DEFAULT_PAGE_COUNT,
   parameter int PAGE_SHIFT = rcpfa_pkg::DEFAULT_PAGE_SHIFT
) (
   input  wire logic                                           clock,
   input  wire logic [31:0]                                    region_start,
   input  wire logic [31:0]                                    region_end,
   input  wire logic [31:0]                                    address,
   input  wire logic [rcpfa_pkg::total_width(PAGE_COUNT)-1:0]  fresh_taken,
   output logic      [31:0]                                    base_address,
   output rcpfa_pkg::check_flags_type                          flags,
   output logic      [rcpfa_pkg::idx_width(PAGE_COUNT)-1:0]    page_index,
   output logic      [rcpfa_pkg::idx_width(PAGE_COUNT)-1:0]    fresh_index
);

   localparam int IDX_W = rcpfa_pkg::idx_width(PAGE_COUNT);
   localparam int TOT_W = rcpfa_pkg::total_width(PAGE_COUNT);
   localparam logic [32:0] PAGE_MASK = 33'((1 << PAGE_SHIFT) - 1);
   localparam logic [32:0] PAGE_LIMIT = 33'(PAGE_COUNT);

   // region base, rounded up to a page boundary
   logic [32:0] base_ff;

   // stage 1
   logic [33:0] rel_ff;
   logic [33:0] span_ff;
   logic        aligned_ff;

   // stage 2
   logic [32:0]      rel_pg;
   logic [32:0]      span_pg;
   logic             rel_ok_ff;
   logic [IDX_W-1:0] rel_idx_ff;
   logic [TOT_W-1:0] total_ff;

   // stage 3
   logic [TOT_W-1:0]            fresh_sub;
   rcpfa_pkg::check_flags_type  flags_ff;
   logic [IDX_W-1:0]            page_index_ff;
   logic [IDX_W-1:0]            fresh_index_ff;

   always_ff @(posedge clock) begin
      base_ff <= ({1'b0, region_start} + PAGE_MASK) & ~PAGE_MASK;
   end

   always_ff @(posedge clock) begin
      rel_ff     <= {2'b00, address} - {1'b0, base_ff};
      span_ff    <= {2'b00, region_end} - {1'b0, base_ff};
      aligned_ff <= (address & PAGE_MASK[31:0]) == 32'd0;
   end

   assign rel_pg  = rel_ff[32:0] >> PAGE_SHIFT;
   assign span_pg = span_ff[32:0] >> PAGE_SHIFT;

   always_ff @(posedge clock) begin
      rel_ok_ff  <= !rel_ff[33] && aligned_ff && (rel_pg < PAGE_LIMIT);
      rel_idx_ff <= rel_pg[IDX_W-1:0];
      if (span_ff[33]) begin
         total_ff <= '0;
      end else if (span_pg >= PAGE_LIMIT) begin
         total_ff <= TOT_W'(PAGE_COUNT);
      end else begin
         total_ff <= span_pg[TOT_W-1:0];
      end
   end

   // fresh pages are handed out from the top down
   assign fresh_sub = total_ff - fresh_taken - TOT_W'(1);

   always_ff @(posedge clock) begin
      flags_ff.addr_ok  <= rel_ok_ff && (TOT_W'(rel_idx_ff) < total_ff);
      flags_ff.fresh_ok <= fresh_taken < total_ff;
      page_index_ff     <= rel_idx_ff;
      fresh_index_ff    <= fresh_sub[IDX_W-1:0];
   end

   assign base_address = base_ff[31:0];
   assign flags        = flags_ff;
   assign page_index   = page_index_ff;
   assign fresh_index  = fresh_index_ff;

endmodule

`default_nettype wire

@@ hw/rtl/refcounted_page_frame_allocator.sv @@
// top level of the reference counted page frame allocator
`timescale 1ns / 1ps
`default_nettype none

// allocates, releases and adds references to physical page frames between
// region_start (rounded up to a page) and region_end. freed pages go on a lifo
// free stack in ram, reference counts live in a second ram. after reset the
// block runs a clearing pass over every entry of the count ram, with busy
// high; csr writes are taken during it. a request is taken when start is high
// and busy is low. its result word is on the rsp_ ports with rsp_valid for
// exactly one cycle, after the request has passed the decode, range, check,
// issue and update states. the receiver cannot stall. a new request is taken
// only once the last one is through: the address and region check runs in the
// decode, range and check states, the memory read is launched in issue, the
// count is modified and written back in update, and the result word is shown
// while idle. csr writes must only happen while idle.
module refcounted_page_frame_allocator #(
   parameter int PAGE_COUNT  = rcpfa_pkg::DEFAULT_PAGE_COUNT,
   parameter int PAGE_SHIFT  = rcpfa_pkg::DEFAULT_PAGE_SHIFT,
   parameter int COUNT_WIDTH = rcpfa_pkg::DEFAULT_COUNT_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_kind,
   input  wire logic [31:0]                           req_address,
   // result channel
   output logic                                       rsp_valid,
   output logic      [2:0]                            rsp_status,
   output logic      [31:0]                           rsp_page_address,
   output logic                                       rsp_page_freed,
   output logic      [7:0]                            rsp_count_after,
   // configuration port
   input  wire logic                                  csr_write_enable,
   input  wire logic [rcpfa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rcpfa_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int IDX_W = rcpfa_pkg::idx_width(PAGE_COUNT);
   localparam int TOT_W = rcpfa_pkg::total_width(PAGE_COUNT);
   localparam int CW    = COUNT_WIDTH;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CLEAR  = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_RANGE  = 7'b0001000,
      ST_CHECK  = 7'b0010000,
      ST_ISSUE  = 7'b0100000,
      ST_UPDATE = 7'b1000000
   } state_type;

   // what the update cycle does
   typedef enum logic [2:0] {
      OP_POP     = 3'd0,
      OP_FRESH   = 3'd1,
      OP_RELEASE = 3'd2,
      OP_ADD     = 3'd3,
      OP_FAIL    = 3'd4
   } op_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [31:0] region_start_ff;
   logic [31:0] region_end_ff;

   // captured request word
   logic [1:0]  req_kind_ff;
   logic [31:0] req_address_ff;

   // allocator bookkeeping
   logic [TOT_W-1:0] depth_ff, depth_in;
   logic [TOT_W-1:0] fresh_ff, fresh_in;
   logic [IDX_W-1:0] clr_ptr_ff;
   logic             clr_last;

   // issue to update hand-off
   op_type                 op_ff, op_in;
   rcpfa_pkg::status_type  fail_ff, fail_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   // result word registers
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_page_address_ff;
   logic        rsp_page_freed_ff;
   logic [7:0]  rsp_count_after_ff;

   // check pipeline
   logic [31:0]                 base_address;
   rcpfa_pkg::check_flags_type  flags;
   logic [IDX_W-1:0]            page_index;
   logic [IDX_W-1:0]            fresh_index;

   // memory ports
   logic             stack_we, stack_re;
   logic [IDX_W-1:0] stack_wr_addr, stack_rd_addr, stack_rd_data;
   logic             ref_we, ref_re;
   logic [IDX_W-1:0] ref_wr_addr;
   logic [CW-1:0]    ref_wr_data, ref_rd_data;

   // update cycle
   logic [TOT_W-1:0]      depth_m1;
   logic [IDX_W-1:0]      idx_sel;
   logic [CW-1:0]         cnt_new;
   logic [CW+7:0]         cnt_ext;
   logic [31:0]           page_offset;
   rcpfa_pkg::status_type status_c;
   logic                  freed_c;
   logic                  alloc_c;
   logic                  push_c;

   rcpfa_check #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_check (
      .clock        (clock),
      .region_start (region_start_ff),
      .region_end   (region_end_ff),
      .address      (req_address_ff),
      .fresh_taken  (fresh_ff),
      .base_address (base_address),
      .flags        (flags),
      .page_index   (page_index),
      .fresh_index  (fresh_index)
   );

   // lifo of freed page indices
   rcpfa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (PAGE_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wr_addr),
      .wr_data (idx_ff),
      .rd_en   (stack_re),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   // per-page reference counts
   rcpfa_ram #(
      .WIDTH (CW),
      .DEPTH (PAGE_COUNT)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wr_addr),
      .wr_data (ref_wr_data),
      .rd_en   (ref_re),
      .rd_addr (page_index),
      .rd_data (ref_rd_data)
   );

   assign busy     = state_ff != ST_IDLE;
   assign clr_last = clr_ptr_ff == IDX_W'(PAGE_COUNT - 1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DECODE: state_in = ST_RANGE;
         ST_RANGE:  state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_ISSUE;
         ST_ISSUE:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ptr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ptr_ff <= clr_ptr_ff + IDX_W'(1);
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= rcpfa_pkg::REGION_START_RESET;
         region_end_ff   <= rcpfa_pkg::REGION_END_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rcpfa_pkg::CSR_REGION_START: region_start_ff <= csr_write_data;
            rcpfa_pkg::CSR_REGION_END:   region_end_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_kind_ff    <= req_kind;
         req_address_ff <= req_address;
      end
   end

   // issue: choose the operation and launch the memory read
   assign depth_m1      = depth_ff - TOT_W'(1);
   assign stack_rd_addr = depth_m1[IDX_W-1:0];

   always_comb begin
      op_in   = OP_FAIL;
      fail_in = rcpfa_pkg::STATUS_BAD_ADDRESS;
      idx_in  = page_index;
      case (req_kind_ff)
         rcpfa_pkg::KIND_ALLOC: begin
            if (depth_ff != '0) begin
               op_in = OP_POP;
            end else if (flags.fresh_ok) begin
               op_in  = OP_FRESH;
               idx_in = fresh_index;
            end else begin
               fail_in = rcpfa_pkg::STATUS_OUT_OF_MEM;
            end
         end
         rcpfa_pkg::KIND_RELEASE: begin
            if (flags.addr_ok) begin
               op_in = OP_RELEASE;
            end
         end
         rcpfa_pkg::KIND_ADD: begin
            if (flags.addr_ok) begin
               op_in = OP_ADD;
            end
         end
         default: ;
      endcase
   end

   assign stack_re = state_ff == ST_ISSUE && op_in == OP_POP;
   assign ref_re   = state_ff == ST_ISSUE && (op_in == OP_RELEASE || op_in == OP_ADD);

   always_ff @(posedge clock) begin
      if (state_ff == ST_ISSUE) begin
         op_ff   <= op_in;
         fail_ff <= fail_in;
         idx_ff  <= idx_in;
      end
   end

   // update: modify the count and write back
   assign idx_sel     = (op_ff == OP_POP) ? stack_rd_data : idx_ff;
   assign page_offset = 32'(idx_sel) << PAGE_SHIFT;

   always_comb begin
      status_c = rcpfa_pkg::STATUS_OK;
      freed_c  = 1'b0;
      alloc_c  = 1'b0;
      cnt_new  = '0;
      case (op_ff)
         OP_POP, OP_FRESH: begin
            alloc_c = 1'b1;
            cnt_new = CW'(1);
         end
         OP_RELEASE: begin
            if (ref_rd_data == '0) begin
               status_c = rcpfa_pkg::STATUS_UNDERFLOW;
            end else begin
               cnt_new = ref_rd_data - CW'(1);
               freed_c = cnt_new == '0;
            end
         end
         OP_ADD: begin
            if (ref_rd_data == '1) begin
               status_c = rcpfa_pkg::STATUS_OVERFLOW;
               cnt_new  = '1;
            end else begin
               cnt_new = ref_rd_data + CW'(1);
            end
         end
         default: status_c = fail_ff;
      endcase
   end

   // a push onto a full stack is dropped
   assign push_c = freed_c && depth_ff < TOT_W'(PAGE_COUNT);

   always_comb begin
      ref_we      = 1'b0;
      ref_wr_addr = idx_sel;
      ref_wr_data = cnt_new;
      if (state_ff == ST_CLEAR) begin
         ref_we      = 1'b1;
         ref_wr_addr = clr_ptr_ff;
         ref_wr_data = '0;
      end else if (state_ff == ST_UPDATE) begin
         ref_we = alloc_c || ((op_ff == OP_RELEASE || op_ff == OP_ADD) &&
                              status_c == rcpfa_pkg::STATUS_OK);
      end
   end

   assign stack_we      = state_ff == ST_UPDATE && push_c;
   assign stack_wr_addr = depth_ff[IDX_W-1:0];

   always_comb begin
      depth_in = depth_ff;
      fresh_in = fresh_ff;
      if (state_ff == ST_UPDATE) begin
         if (op_ff == OP_POP) begin
            depth_in = depth_m1;
         end else if (push_c) begin
            depth_in = depth_ff + TOT_W'(1);
         end
         if (op_ff == OP_FRESH) begin
            fresh_in = fresh_ff + TOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         fresh_ff <= '0;
      end else begin
         depth_ff <= depth_in;
         fresh_ff <= fresh_in;
      end
   end

   // result word, shown for one cycle after the update
   assign cnt_ext = {8'd0, cnt_new};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= state_ff == ST_UPDATE;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         rsp_status_ff       <= status_c;
         rsp_page_address_ff <= alloc_c ? base_address + page_offset : 32'd0;
         rsp_page_freed_ff   <= freed_c;
         rsp_count_after_ff  <= cnt_ext[7:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_address_ff;
   assign rsp_page_freed   = rsp_page_freed_ff;
   assign rsp_count_after  = rsp_count_after_ff;

`ifndef SYNTHESIS
   // every accepted request gives its result word
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##6 rsp_valid)
      else $error("result word missing after accepted request");

   // result words never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result words in consecutive cycles");

   // a freed page only comes from a clean release down to zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_freed |->
         rsp_status == rcpfa_pkg::STATUS_OK && rsp_count_after == 8'd0)
      else $error("page freed with bad status or nonzero count");

   // the free stack never holds more than every page
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= TOT_W'(PAGE_COUNT))
      else $error("free stack depth past page count");

   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
`endif

endmodule

`default_nettype wire
